FILE: hw/rtl/agk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agk_pkg
// Shared widths, register map, exp(-x) table and stage request types for the
// anisotropic 3D Gaussian evaluator.
// ----------------------------------------------------------------------------
package agk_pkg;

    localparam int FRAC_BITS         = 16;
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_RANGE_LOG2    = 4;
    localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);
    localparam int FRAC_E_W          = FRAC_BITS + EXP_RANGE_LOG2;

    localparam int COORD_W  = 32;
    localparam int SQ_LO_W  = 32;
    localparam int SQ_W     = 2 * COORD_W - FRAC_BITS;
    localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
    localparam int A_W      = SQ_HI_W + 32;
    localparam int TERM_W   = 63;
    localparam int E_W      = 64;
    localparam int Q31_W    = 32;
    localparam int LANES    = 3;
    localparam int PIPE_LAT = 10;

    localparam int REG_ADDR_W = 5;

    localparam logic [TERM_W-1:0]   TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};
    localparam longint unsigned     A_CAP_VAL = 64'd1 << (62 - SQ_HI_W);
    localparam logic [A_W-1:0]      A_CAP = A_W'(A_CAP_VAL);
    localparam logic [Q31_W-1:0]    ONE_Q31 = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_AMPLITUDE      = 3'd0,
        REG_CENTER_X       = 3'd1,
        REG_CENTER_Y       = 3'd2,
        REG_CENTER_Z       = 3'd3,
        REG_INV_SQ_SIGMA_X = 3'd4,
        REG_INV_SQ_SIGMA_Y = 3'd5,
        REG_INV_SQ_SIGMA_Z = 3'd6
    } t_reg_idx;

    typedef logic [EXP_TABLE_ENTRIES:0][Q31_W-1:0] t_exp_tab;

    // Table lookup request handed from the exponent sum to the exp/scale path
    typedef struct packed {
        logic                 vld;
        logic                 uf;
        logic [EXP_IDX_W-1:0] idx;
        logic [FRAC_E_W-1:0]  frac;
    } t_exp_req;

    // exp(-k*h) in Q1.31, h = 16 / EXP_TABLE_ENTRIES; step factor from a Taylor series
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab          tab;
        longint unsigned   h;
        longint unsigned   t;
        longint unsigned   e1;
        longint unsigned   cur;
        longint            sum;
        logic              done;
        h    = (64'd16 << 31) / EXP_TABLE_ENTRIES;
        sum  = 64'sd2147483648;
        t    = 64'd2147483648;
        done = 1'b0;
        for (int n = 1; n < 64; n++) begin
            if (!done) begin
                t = ((t * h) >> 31) / 64'(n);
                if (t == 64'd0) begin
                    done = 1'b1;
                end else if (n[0]) begin
                    sum = sum - $signed(t);
                end else begin
                    sum = sum + $signed(t);
                end
            end
        end
        e1     = (sum > 0) ? $unsigned(sum) : 64'd0;
        tab[0] = ONE_Q31;
        cur    = 64'd2147483648;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            cur        = (cur * e1 + (64'd1 << 30)) >> 31;
            tab[k + 1] = cur[Q31_W-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

FILE: hw/rtl/agk_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agk_lane
// One axis: offset from the center, square, weight by the inverse squared
// sigma and saturate. Four register stages, a new request every cycle.
// ----------------------------------------------------------------------------
module agk_lane import agk_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [COORD_W-1:0] i_point,
    input  logic signed [COORD_W-1:0] i_center,
    input  logic        [31:0]        i_inv,
    output logic        [TERM_W-1:0]  o_term
);

    logic signed [COORD_W:0]   n_diff;
    logic        [COORD_W-1:0] n_mag;
    logic        [COORD_W-1:0] r_mag;
    logic        [63:0]        n_prod;
    logic        [SQ_W-1:0]    r_sq;
    logic        [A_W-1:0]     n_a;
    logic        [A_W-1:0]     r_a;
    logic        [63:0]        n_b;
    logic        [63:0]        r_b;
    logic        [64:0]        n_wide;
    logic                      n_sat;
    logic        [TERM_W-1:0]  n_term;
    logic        [TERM_W-1:0]  r_term;

    always_comb begin
        n_diff = (COORD_W+1)'(i_point) - (COORD_W+1)'(i_center);
        // the magnitude always fits in 32 bits
        n_mag  = n_diff[COORD_W] ? COORD_W'(-n_diff) : n_diff[COORD_W-1:0];
        n_prod = {32'd0, r_mag} * {32'd0, r_mag};
        // split the square so that each product stays within 32 by 32 bits
        n_a    = A_W'(r_sq[SQ_W-1:SQ_LO_W]) * A_W'(i_inv);
        n_b    = {32'd0, r_sq[SQ_LO_W-1:0]} * {32'd0, i_inv};
        n_sat  = (r_a > A_CAP);
        n_wide = (65'(r_a) << SQ_HI_W) + 65'(r_b >> FRAC_BITS);
        n_term = (n_sat || (n_wide > 65'(TERM_CAP))) ? TERM_CAP : n_wide[TERM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_sq   <= n_prod[63:FRAC_BITS];
        r_a    <= n_a;
        r_b    <= n_b;
        r_term <= n_term;
    end

    assign o_term = r_term;

endmodule

FILE: hw/rtl/agk_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agk_merge
// Sums the lane terms into the exponent, flags underflow and splits the
// exponent into table index and interpolation fraction.
// ----------------------------------------------------------------------------
module agk_merge import agk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [TERM_W-1:0] i_term [LANES],
    output t_exp_req          o_req
);

    logic [E_W-1:0]        n_e;
    logic [FRAC_E_W-1:0]   n_e_lo;
    t_exp_req              n_req;
    t_exp_req              r_req;

    always_comb begin
        n_e = '0;
        for (int i = 0; i < LANES; i++) begin
            n_e = n_e + E_W'(i_term[i]);
        end
        n_e_lo     = n_e[FRAC_E_W-1:0];
        n_req.vld  = i_vld;
        n_req.uf   = |n_e[E_W-1:FRAC_E_W];
        n_req.idx  = n_e[FRAC_E_W-1 -: EXP_IDX_W];
        n_req.frac = n_e_lo << EXP_IDX_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.vld <= 1'b0;
        end else begin
            r_req.vld <= n_req.vld;
        end
        r_req.uf   <= n_req.uf;
        r_req.idx  <= n_req.idx;
        r_req.frac <= n_req.frac;
    end

    assign o_req = r_req;

endmodule

FILE: hw/rtl/agk_exp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agk_exp_scale
// Table lookup with linear interpolation of exp(-e), then scaling by the
// amplitude. Five register stages ending in the result register.
// ----------------------------------------------------------------------------
module agk_exp_scale import agk_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_exp_req                  i_req,
    input  logic signed [31:0]        i_amplitude,
    output logic                      o_strobe,
    output logic signed [31:0]        o_density,
    output logic                      o_underflow
);

    localparam int PROD_W = Q31_W + FRAC_E_W;

    // valid and underflow per stage: lookup, multiply, interpolate, scale
    logic [3:0]               r_vld;
    logic [3:0]               r_uf;

    logic [EXP_IDX_W:0]       n_idx_hi;
    logic [EXP_IDX_W:0]       n_idx_lo;
    logic [Q31_W-1:0]         n_hi;
    logic [Q31_W-1:0]         n_lo;
    logic [Q31_W-1:0]         r_hi_a;
    logic [Q31_W-1:0]         r_diff;
    logic [FRAC_E_W-1:0]      r_frac;

    logic [PROD_W-1:0]        n_prod;
    logic [PROD_W-1:0]        r_prod;
    logic [Q31_W-1:0]         r_hi_b;

    logic [Q31_W-1:0]         n_v;
    logic [Q31_W-1:0]         r_v;
    logic [31:0]              n_amp_mag;
    logic [31:0]              r_amp_mag;
    logic                     r_amp_neg_c;

    logic [63:0]              n_mag;
    logic [63:0]              r_mag;
    logic                     r_amp_neg_d;

    logic [31:0]              n_mag31;
    logic [31:0]              n_density;
    logic                     r_strobe;
    logic signed [31:0]       r_density;
    logic                     r_underflow;

    always_comb begin
        n_idx_hi  = {1'b0, i_req.idx};
        n_idx_lo  = n_idx_hi + 1'b1;
        n_hi      = EXP_TAB[n_idx_hi];
        n_lo      = EXP_TAB[n_idx_lo];
        n_prod    = PROD_W'(r_diff) * PROD_W'(r_frac);
        n_v       = r_hi_b - r_prod[FRAC_E_W +: Q31_W];
        n_amp_mag = i_amplitude[31] ? 32'(-i_amplitude) : i_amplitude;
        n_mag     = {32'd0, r_amp_mag} * {32'd0, r_v};
        n_mag31   = r_mag[62:31];
        if (r_uf[3]) begin
            n_density = '0;
        end else begin
            n_density = r_amp_neg_d ? (32'd0 - n_mag31) : n_mag31;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[2:0], i_req.vld};
            r_strobe <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_uf        <= {r_uf[2:0], i_req.uf};
        r_hi_a      <= n_hi;
        r_diff      <= n_hi - n_lo;
        r_frac      <= i_req.frac;
        r_prod      <= n_prod;
        r_hi_b      <= r_hi_a;
        r_v         <= n_v;
        r_amp_mag   <= n_amp_mag;
        r_amp_neg_c <= i_amplitude[31];
        r_mag       <= n_mag;
        r_amp_neg_d <= r_amp_neg_c;
        r_density   <= n_density;
        r_underflow <= r_uf[3];
    end

    assign o_strobe    = r_strobe;
    assign o_density   = r_density;
    assign o_underflow = r_underflow;

    a_interp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && !r_uf[2] |-> r_v <= ONE_Q31)
        else $error("interpolated exp value above one");

    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_underflow |-> o_density == 32'sd0)
        else $error("underflow result with nonzero density");

endmodule

FILE: hw/rtl/anisotropic_gaussian_3d_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anisotropic_gaussian_3d_eval_unit
// Evaluates amplitude * exp(-sum(w_i * (p_i - c_i)^2)) for one query point
// per request, three axis lanes feeding a merge and an exp/scale pipeline.
//
//   channel   direction  handshake               payload
//   request   in         start, busy             i_point_x/y/z
//   result    out        o_strobe (one cycle)    o_density, o_underflow
//   config    in/out     APB psel/penable/...    paddr, pwdata, prdata
//
// One request per cycle; busy stays low.
// A result passes through 4 lane stages, then the exponent sum register,
// 4 exp/scale stages and the output register.
// Each lane's squaring and weighting multipliers set the stage count.
// Synchronous reset clears the pipeline valids and loads register defaults.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module anisotropic_gaussian_3d_eval_unit import agk_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    output logic                      o_strobe,
    output logic signed [31:0]        o_density,
    output logic                      o_underflow,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [REG_ADDR_W-1:0]     paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic signed [31:0]        r_amplitude;
    logic signed [COORD_W-1:0] r_center [LANES];
    logic        [31:0]        r_inv [LANES];
    logic signed [COORD_W-1:0] w_point [LANES];
    logic        [TERM_W-1:0]  w_term [LANES];
    logic                      w_accept;
    logic                      w_cfg_wr;
    t_reg_idx                  w_reg;
    logic [3:0]                r_lane_vld;
    t_exp_req                  w_req;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[REG_ADDR_W-1:2]);

    assign w_point[0] = i_point_x;
    assign w_point[1] = i_point_y;
    assign w_point[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= 32'sd65536;
            for (int i = 0; i < LANES; i++) begin
                r_center[i] <= '0;
                r_inv[i]    <= 32'd65536;
            end
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_AMPLITUDE:      r_amplitude <= pwdata;
                REG_CENTER_X:       r_center[0] <= pwdata;
                REG_CENTER_Y:       r_center[1] <= pwdata;
                REG_CENTER_Z:       r_center[2] <= pwdata;
                REG_INV_SQ_SIGMA_X: r_inv[0]    <= pwdata;
                REG_INV_SQ_SIGMA_Y: r_inv[1]    <= pwdata;
                REG_INV_SQ_SIGMA_Z: r_inv[2]    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_AMPLITUDE:      prdata = r_amplitude;
            REG_CENTER_X:       prdata = r_center[0];
            REG_CENTER_Y:       prdata = r_center[1];
            REG_CENTER_Z:       prdata = r_center[2];
            REG_INV_SQ_SIGMA_X: prdata = r_inv[0];
            REG_INV_SQ_SIGMA_Y: prdata = r_inv[1];
            REG_INV_SQ_SIGMA_Z: prdata = r_inv[2];
            default:            prdata = '0;
        endcase
    end

    // track requests through the four lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_vld <= '0;
        end else begin
            r_lane_vld <= {r_lane_vld[2:0], w_accept};
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        agk_lane u_lane (
            .i_clk    (i_clk),
            .i_point  (w_point[g]),
            .i_center (r_center[g]),
            .i_inv    (r_inv[g]),
            .o_term   (w_term[g])
        );
    end

    agk_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_lane_vld[3]),
        .i_term  (w_term),
        .o_req   (w_req)
    );

    agk_exp_scale u_exp_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_amplitude (r_amplitude),
        .o_strobe    (o_strobe),
        .o_density   (o_density),
        .o_underflow (o_underflow)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##PIPE_LAT o_strobe)
        else $error("request produced no result at the expected cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, PIPE_LAT))
        else $error("result without a matching request");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the anisotropic 3D Gaussian evaluator. A local
// fixed-point predictor, with its own exp(-x) ladder, computes density and
// underflow for every accepted request. A monitor checks each strobed result
// against the oldest prediction. Directed corner tests are followed by random
// phases, each under its own register setting, with bursty request traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import agk_pkg::*;

    typedef struct packed {
        logic signed [31:0] density;
        logic               underflow;
    } t_density_result;

    localparam logic [63:0] WEIGHT_CAP = 64'd1 << 62;
    localparam int          PRINT_CAP  = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic signed [COORD_W-1:0] i_point_z;
    logic                  o_strobe;
    logic signed [31:0]    o_density;
    logic                  o_underflow;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // exp(-k*h) in Q1.31, one entry per interval edge
    logic [63:0]     exp_ladder [0:EXP_TABLE_ENTRIES];
    logic [31:0]     shadow_reg [0:6];
    t_density_result density_q [$];
    int              mismatch_count = 0;
    int              burst_left = 0;

    anisotropic_gaussian_3d_eval_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .o_strobe    (o_strobe),
        .o_density   (o_density),
        .o_underflow (o_underflow),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("ERROR @%0t: %s got %h want %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic void fill_exp_ladder();
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] factor;
        longint      acc;
        int          n;
        step = (64'd16 << 31) / EXP_TABLE_ENTRIES;
        acc  = 64'sd2147483648;
        term = 64'd1 << 31;
        n    = 1;
        // Taylor series of exp(-h), alternating signs, until a term vanishes
        while (n < 64) begin
            term = ((term * step) >> 31) / 64'(n);
            if (term == 64'd0) begin
                n = 64;
            end else begin
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
                n++;
            end
        end
        factor = (acc > 0) ? 64'(acc) : 64'd0;
        exp_ladder[0] = 64'd1 << 31;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            exp_ladder[k + 1] = (exp_ladder[k] * factor + (64'd1 << 30)) >> 31;
        end
    endfunction

    // weighted squared offset of one axis, saturated
    function automatic logic [63:0] axis_weight(input logic [31:0] p, input logic [31:0] c,
                                                input logic [31:0] w);
        logic signed [32:0] d;
        logic [32:0]        m;
        logic [63:0]        sq;
        logic [127:0]       prod;
        d    = $signed({p[31], p}) - $signed({c[31], c});
        m    = d[32] ? 33'(-d) : 33'(d);
        sq   = (64'(m) * 64'(m)) >> FRAC_BITS;
        prod = (128'(sq) * 128'(w)) >> FRAC_BITS;
        return (prod > 128'(WEIGHT_CAP)) ? WEIGHT_CAP : prod[63:0];
    endfunction

    function automatic t_density_result gaussian_density(input logic [31:0] px,
                                                         input logic [31:0] py,
                                                         input logic [31:0] pz);
        t_density_result r;
        logic [63:0]     e;
        logic [63:0]     s;
        logic [63:0]     f;
        logic [63:0]     hi;
        logic [63:0]     lo;
        logic [63:0]     v;
        logic [63:0]     amag;
        logic [63:0]     mag;
        logic [63:0]     signed_mag;
        longint          amp_s;
        int              idx;
        e = axis_weight(px, shadow_reg[REG_CENTER_X], shadow_reg[REG_INV_SQ_SIGMA_X])
          + axis_weight(py, shadow_reg[REG_CENTER_Y], shadow_reg[REG_INV_SQ_SIGMA_Y])
          + axis_weight(pz, shadow_reg[REG_CENTER_Z], shadow_reg[REG_INV_SQ_SIGMA_Z]);
        if (e >= (64'd1 << FRAC_E_W)) begin
            r.density   = 32'sd0;
            r.underflow = 1'b1;
            return r;
        end
        s   = e * 64'(EXP_TABLE_ENTRIES);
        idx = int'(s >> FRAC_E_W);
        if (idx >= EXP_TABLE_ENTRIES) begin
            idx = EXP_TABLE_ENTRIES - 1;
        end
        f  = s & ((64'd1 << FRAC_E_W) - 64'd1);
        hi = exp_ladder[idx];
        lo = exp_ladder[idx + 1];
        v  = hi - (((hi - lo) * f) >> FRAC_E_W);
        amp_s = longint'($signed(shadow_reg[REG_AMPLITUDE]));
        amag  = (amp_s < 0) ? 64'(-amp_s) : 64'(amp_s);
        mag   = (amag * v) >> 31;
        signed_mag  = (amp_s < 0) ? (64'd0 - mag) : mag;
        r.density   = signed_mag[31:0];
        r.underflow = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_density_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (density_q.size() == 0) begin
                report_mismatch("result with no request", o_density, 32'd0);
            end else begin
                want = density_q.pop_front();
                if (o_density !== want.density) begin
                    report_mismatch("density", o_density, want.density);
                end
                if (o_underflow !== want.underflow) begin
                    report_mismatch("underflow", 32'(o_underflow), 32'(want.underflow));
                end
            end
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        density_q = {density_q, gaussian_density(x, y, z)};
    endtask

    // bursts of back-to-back requests separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // hold requests until every prediction is matched and the pipe is empty
    task automatic settle();
        start <= 1'b0;
        while (density_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic apb_cycle(input logic wr, input t_reg_idx idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_cycle(1'b1, idx, value, rd);
        shadow_reg[idx] = value;
        apb_cycle(1'b0, idx, 32'd0, rd);
        if (rd !== value) begin
            report_mismatch("register readback", rd, value);
        end
    endtask

    task automatic set_config(input logic [31:0] amp, input logic [31:0] cx,
                              input logic [31:0] cy, input logic [31:0] cz,
                              input logic [31:0] wx, input logic [31:0] wy,
                              input logic [31:0] wz);
        settle();
        program_reg(REG_AMPLITUDE, amp);
        program_reg(REG_CENTER_X, cx);
        program_reg(REG_CENTER_Y, cy);
        program_reg(REG_CENTER_Z, cz);
        program_reg(REG_INV_SQ_SIGMA_X, wx);
        program_reg(REG_INV_SQ_SIGMA_Y, wy);
        program_reg(REG_INV_SQ_SIGMA_Z, wz);
    endtask

    function automatic logic [31:0] pick3(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        case ($urandom_range(0, 2))
            0:       return a;
            1:       return b;
            default: return c;
        endcase
    endfunction

    // mostly near the centre at a random scale, the rest anywhere
    function automatic logic [31:0] near_coord(input logic [31:0] c);
        logic signed [31:0] ofs;
        if ($urandom_range(0, 6) == 0) begin
            return $urandom;
        end
        ofs = $urandom;
        ofs = ofs >>> $urandom_range(8, 31);
        return c + ofs;
    endfunction

    task automatic random_config(input int flavor);
        logic [31:0] w;
        case (flavor)
            0: set_config($urandom, $urandom, $urandom, $urandom,
                          $urandom_range(256, 1 << 22), $urandom_range(256, 1 << 22),
                          $urandom_range(256, 1 << 22));
            1: begin
                w = $urandom_range(256, 1 << 22);
                set_config(32'($urandom_range(1, 64)) << 16, $urandom, $urandom, $urandom,
                           w, w, w);
            end
            2: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            default: set_config(pick3(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000),
                                pick3(32'h8000_0000, 32'h7FFF_FFFF, 32'd0),
                                pick3(32'h8000_0000, 32'h7FFF_FFFF, 32'd0),
                                pick3(32'h8000_0000, 32'h7FFF_FFFF, 32'd0),
                                pick3(32'd1, 32'hFFFF_FFFF, 32'h0001_0000),
                                pick3(32'd1, 32'hFFFF_FFFF, 32'h0001_0000),
                                pick3(32'd1, 32'hFFFF_FFFF, 32'h0001_0000));
        endcase
    endtask

    task automatic test_reset_defaults();
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h0001_0000, 32'd0, 32'd0);
        send_point(32'd0, 32'hFFFF_0000, 32'h0000_8000);
    endtask

    task automatic test_register_access();
        set_config(32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'hF0F0_0F0F,
                   32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
        set_config(32'h0001_0000, 32'd0, 32'd0, 32'd0,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    endtask

    task automatic test_coordinate_extremes();
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // largest offsets times largest weights pin every term at the cap; the second point has two axes at zero offset
    task automatic test_term_saturation();
        set_config(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    task automatic test_zero_weight();
        set_config(32'h0003_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
        set_config(32'h0003_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
        send_point(32'h8000_0000, 32'h0001_8000, 32'h7FFF_FFFF);
    endtask

    // exponent just inside and exactly at the table range, and on interval edges
    task automatic test_table_edges();
        set_config(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'd262143, 32'd0, 32'd0);
        send_point(32'd262144, 32'd0, 32'd0);
        send_point(32'h0001_0000, 32'd0, 32'd0);
        send_point(32'd0, 32'h0000_0001, 32'hFFFF_FFFF);
    endtask

    task automatic test_negative_amplitude();
        set_config(32'h8000_0000, 32'd0, 32'd0, 32'd0,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h0000_C000, 32'hFFFF_4000, 32'd0);
        set_config(32'hFFFF_0000, 32'd0, 32'd0, 32'd0,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    endtask

    task automatic test_equal_sigmas();
        set_config(32'h0002_0000, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_4000,
                   32'h0004_0000, 32'h0004_0000, 32'h0004_0000);
        send_point(32'h0010_4000, 32'hFFEF_C000, 32'h0000_0000);
        send_point(32'h000F_8000, 32'hFFF0_8000, 32'h0000_8000);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++) begin
            random_config(phase % 4);
            burst_left = 0;
            for (int n = 0; n < 140; n++) begin
                send_point(near_coord(shadow_reg[REG_CENTER_X]),
                           near_coord(shadow_reg[REG_CENTER_Y]),
                           near_coord(shadow_reg[REG_CENTER_Z]));
                pace_sender();
            end
        end
    endtask

    initial begin
        fill_exp_ladder();
        shadow_reg[REG_AMPLITUDE]      = 32'h0001_0000;
        shadow_reg[REG_CENTER_X]       = 32'd0;
        shadow_reg[REG_CENTER_Y]       = 32'd0;
        shadow_reg[REG_CENTER_Z]       = 32'd0;
        shadow_reg[REG_INV_SQ_SIGMA_X] = 32'h0001_0000;
        shadow_reg[REG_INV_SQ_SIGMA_Y] = 32'h0001_0000;
        shadow_reg[REG_INV_SQ_SIGMA_Z] = 32'h0001_0000;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_point_x <= '0;
        i_point_y <= '0;
        i_point_z <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_coordinate_extremes();
        test_register_access();
        test_term_saturation();
        test_zero_weight();
        test_table_edges();
        test_negative_amplitude();
        test_equal_sigmas();
        test_random_phases();

        settle();
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (density_q.size() != 0) begin
            report_mismatch("requests without result", 32'(density_q.size()), 32'd0);
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: anisotropic_gaussian_3d_eval_unit.f
hw/rtl/agk_pkg.sv
hw/rtl/agk_lane.sv
hw/rtl/agk_merge.sv
hw/rtl/agk_exp_scale.sv
hw/rtl/anisotropic_gaussian_3d_eval_unit.sv
bench/tb_top.sv
